[design/gccs_pkg.sv]
// Shared types and constants of the group call slot controller.
package gccs_pkg;

  localparam int NSLOT = 4;
  localparam int SLOT_W = 2;
  localparam int MAX_RES = 12;
  localparam int CNT_W = 4;

  localparam logic [31:0] STALE_RST = 32'd30000;
  localparam logic [15:0] SPACING_RST = 16'd113;
  localparam logic [5:0] MARKER_RST = 6'd21;

  localparam logic [1:0] CFG_STALE = 2'd0;
  localparam logic [1:0] CFG_SPACING = 2'd1;
  localparam logic [1:0] CFG_MARKER = 2'd2;

  localparam logic [2:0] REQ_SETUP = 3'd0;
  localparam logic [2:0] REQ_TXDEM = 3'd1;
  localparam logic [2:0] REQ_TXCEASE = 3'd2;
  localparam logic [2:0] REQ_DISC = 3'd4;

  localparam logic [3:0] K_CONNECT = 4'd0;
  localparam logic [3:0] K_SETUP = 4'd1;
  localparam logic [3:0] K_GRANT = 4'd2;
  localparam logic [3:0] K_CEASED = 4'd3;
  localparam logic [3:0] K_RELEASE = 4'd4;
  localparam logic [3:0] K_EXPIRED = 4'd5;
  localparam logic [3:0] K_NOSLOT = 4'd6;
  localparam logic [3:0] K_NOCALL = 4'd7;
  localparam logic [3:0] K_INVALID = 4'd8;
  localparam logic [3:0] K_NOTHING = 4'd9;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CONNECTED = 2'd2;
  localparam logic [1:0] PH_TALKER = 2'd3;

  typedef struct packed {
    logic [3:0] kind;
    logic [23:0] target;
    logic [23:0] calling;
    logic [13:0] ident;
    logic seq;
    logic [4:0] cause;
    logic grp;
    logic hook;
    logic dup;
  } res_t;

  typedef struct packed {
    logic capture;
    logic req;
    logic voice;
    logic stage;
    logic notice;
    logic expire;
    logic fin;
    logic load;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0] rd;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic [CNT_W-1:0] count;
    logic out_hold;
  } stat_t;

endpackage

[design/group_call_control_slots.sv]
// Top level of the group call slot controller.
//
//   channel  direction  handshake             content
//   in       sink       in_valid / in_stall   one request or tick
//   out      source     out_valid / out_stall one result beat, last marks the end
//   cfg      sink       cfg_we                register write
//
// A request goes through the request and finish states before its beat is ready; a tick
// adds the sequential three-step walk over the four call slots between those two states.
// Results then leave one beat per cycle from the result buffer while out is not stalled.
// in_stall is high from acceptance until the last beat sits in the output register.
// Reset is synchronous and clears all slots and restores register defaults.
module group_call_control_slots import gccs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [2:0]  req_type,
  input  logic [23:0] caller_addr,
  input  logic [1:0]  called_kind,
  input  logic [23:0] called_addr,
  input  logic [1:0]  comm_type,
  input  logic        group_registered,
  input  logic        hook_sel,
  input  logic        duplex_sel,
  input  logic [4:0]  release_cause,
  input  logic [31:0] now_ms,
  input  logic [15:0] voice_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  result_kind,
  output logic [23:0] target_addr,
  output logic [23:0] calling_addr,
  output logic [13:0] call_ident,
  output logic        send_seq,
  output logic [4:0]  cause_out,
  output logic        is_group,
  output logic        hook_out,
  output logic        duplex_out,
  output logic [3:0]  voice_mask,
  output logic [31:0] marker_word,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  stat_t stat;
  res_t ores;

  gccs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  gccs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .action(action), .req_type(req_type), .caller_addr(caller_addr),
    .called_kind(called_kind), .called_addr(called_addr), .comm_type(comm_type),
    .group_registered(group_registered), .hook_sel(hook_sel),
    .duplex_sel(duplex_sel), .release_cause(release_cause), .now_ms(now_ms),
    .voice_count(voice_count), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_stall(out_stall),
    .ores(ores), .voice_mask(voice_mask), .marker_word(marker_word), .last(last)
  );

  assign result_kind = ores.kind;
  assign target_addr = ores.target;
  assign calling_addr = ores.calling;
  assign call_ident = ores.ident;
  assign send_seq = ores.seq;
  assign cause_out = ores.cause;
  assign is_group = ores.grp;
  assign hook_out = ores.hook;
  assign duplex_out = ores.dup;

endmodule

[design/gccs_ctrl.sv]
// Sequencer that steps one item through request, slot scan and result drain.
module gccs_ctrl import gccs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REQ = 3'd1;
  localparam logic [2:0] S_STAGE = 3'd2;
  localparam logic [2:0] S_NOTICE = 3'd3;
  localparam logic [2:0] S_EXPIRE = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state, state_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [CNT_W-1:0] rd, rd_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    slot_next = slot;
    rd_next = rd;
    cmd = '0;
    cmd.slot = slot;
    cmd.rd = rd;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_REQ;
        end
      end
      S_REQ: begin
        cmd.req = !stat.tick;
        cmd.voice = stat.tick;
        slot_next = '0;
        state_next = stat.tick ? S_STAGE : S_FIN;
      end
      S_STAGE: begin
        cmd.stage = 1'b1;
        state_next = S_NOTICE;
      end
      S_NOTICE: begin
        cmd.notice = 1'b1;
        state_next = S_EXPIRE;
      end
      S_EXPIRE: begin
        cmd.expire = 1'b1;
        if (slot == SLOT_W'(NSLOT - 1)) begin
          state_next = S_FIN;
        end else begin
          slot_next = slot + 1'b1;
          state_next = S_STAGE;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        rd_next = '0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_hold) begin
          cmd.load = 1'b1;
          if (rd == stat.count - 1'b1) begin
            state_next = S_IDLE;
          end else begin
            rd_next = rd + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= '0;
      rd <= '0;
    end else begin
      state <= state_next;
      slot <= slot_next;
      rd <= rd_next;
    end
  end

endmodule

[design/gccs_dp.sv]
// Slot table, configuration, result buffer and output register.
module gccs_dp import gccs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        action,
  input  logic [2:0]  req_type,
  input  logic [23:0] caller_addr,
  input  logic [1:0]  called_kind,
  input  logic [23:0] called_addr,
  input  logic [1:0]  comm_type,
  input  logic        group_registered,
  input  logic        hook_sel,
  input  logic        duplex_sel,
  input  logic [4:0]  release_cause,
  input  logic [31:0] now_ms,
  input  logic [15:0] voice_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        ores,
  output logic [3:0]  voice_mask,
  output logic [31:0] marker_word,
  output logic        last
);

  logic [31:0] stale_cfg;
  logic [15:0] spacing_cfg;
  logic [5:0] marker_cfg;

  logic tick;
  logic [2:0] rq;
  logic [23:0] caller, called;
  logic [1:0] ckind, ctype;
  logic reg_grp, hook, dup;
  logic [4:0] cause;
  logic [31:0] now;
  logic [15:0] vcnt;

  logic [23:0] owner [NSLOT];
  logic [13:0] ident [NSLOT];
  logic [1:0] phase [NSLOT];
  logic [23:0] gaddr [NSLOT];
  logic [23:0] paddr [NSLOT];
  logic [2:0] flags [NSLOT];
  logic [1:0] stg [NSLOT];
  logic [31:0] due [NSLOT];
  logic [31:0] act [NSLOT];
  logic [5:0] mark [NSLOT];

  logic [13:0] next_ident, nid_inc;
  logic [15:0] vlast;
  logic [31:0] vbump;
  logic vseen, quiet_zero, fired2;

  res_t rbuf [MAX_RES];
  logic [CNT_W-1:0] count;

  logic [NSLOT-1:0] occ;
  logic found, any_occ, bad, alloc, setup_ok;
  logic [SLOT_W-1:0] fidx, freeidx, sreq;
  logic [23:0] cp;
  logic g;

  logic [SLOT_W-1:0] sl;
  logic [31:0] dlt, act_new, age;
  logic fire, expire;

  logic wr_en;
  res_t ent;
  logic [3:0] vm_now;
  logic [31:0] mw_now;

  assign sl = cmd.slot;
  assign stat.tick = tick;
  assign stat.count = count;
  assign stat.out_hold = out_valid && out_stall;

  // Slot lookup for a request; lowest index wins.
  always_comb begin
    found = 1'b0;
    fidx = '0;
    freeidx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      occ[i] = (owner[i] != '0);
      if (owner[i] == caller && caller != '0) begin
        found = 1'b1;
        fidx = SLOT_W'(i);
      end
      if (owner[i] == '0) freeidx = SLOT_W'(i);
    end
    any_occ = |occ;
  end

  assign bad = (caller == '0) || (rq > REQ_DISC);
  assign alloc = !found && !any_occ;
  assign setup_ok = found || alloc;
  assign sreq = found ? fidx : freeidx;
  assign cp = (ckind == 2'd1 || ckind == 2'd2) ? called : 24'd0;
  assign g = (cp != '0) && (ctype != '0) && reg_grp;
  assign nid_inc = (next_ident + 1'b1 == '0) ? 14'd1 : next_ident + 1'b1;

  assign dlt = now - due[sl];
  assign fire = occ[sl] && (stg[sl] != '0) && !dlt[31];
  assign act_new = quiet_zero ? now : act[sl];
  assign age = now - act_new;
  assign expire = occ[sl] && (phase[sl] != PH_IDLE) && (age > stale_cfg);

  // The one result written into the buffer this cycle, if any.
  always_comb begin
    wr_en = 1'b0;
    ent = '0;
    if (cmd.req) begin
      wr_en = 1'b1;
      ent.target = caller;
      if (bad) begin
        ent.kind = K_INVALID;
      end else if (rq == REQ_SETUP) begin
        if (!setup_ok) begin
          ent.kind = K_NOSLOT;
        end else begin
          ent.kind = K_CONNECT;
          ent.ident = alloc ? next_ident : ident[sreq];
          ent.seq = alloc ? 1'b0 : flags[sreq][2];
          ent.grp = g;
          ent.hook = hook;
          ent.dup = dup;
        end
      end else if (!found) begin
        ent.kind = K_NOCALL;
      end else begin
        ent.ident = ident[fidx];
        ent.grp = (gaddr[fidx] != '0);
        if (rq == REQ_TXDEM) begin
          ent.kind = K_GRANT;
          ent.seq = !flags[fidx][2];
        end else if (rq == REQ_TXCEASE) begin
          ent.kind = K_CEASED;
          ent.target = (gaddr[fidx] != '0) ? gaddr[fidx] : owner[fidx];
        end else begin
          ent.kind = K_RELEASE;
          ent.seq = !flags[fidx][2];
          ent.cause = cause;
        end
      end
    end else if (cmd.stage || cmd.notice || cmd.expire) begin
      ent.target = owner[sl];
      ent.ident = ident[sl];
      ent.seq = flags[sl][2];
      ent.grp = (gaddr[sl] != '0);
      if (cmd.stage) begin
        wr_en = fire && (stg[sl] == 2'd1 || stg[sl] == 2'd2);
        ent.kind = K_CONNECT;
        ent.hook = flags[sl][0];
        ent.dup = flags[sl][1];
      end else if (cmd.notice) begin
        wr_en = fired2 && (gaddr[sl] != '0 || paddr[sl] != '0);
        ent.kind = K_SETUP;
        ent.target = (gaddr[sl] != '0) ? gaddr[sl] : paddr[sl];
        ent.calling = owner[sl];
      end else begin
        wr_en = expire;
        ent.kind = K_EXPIRED;
      end
    end else if (cmd.fin) begin
      wr_en = (count == '0);
      ent.kind = K_NOTHING;
    end
  end

  always_comb begin
    vm_now = '0;
    mw_now = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (occ[i] && phase[i] != PH_IDLE) vm_now[3] = 1'b1;
      if (occ[i]) mw_now[29:24] = mw_now[29:24] | mark[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tick <= action;
      rq <= req_type;
      caller <= caller_addr;
      ckind <= called_kind;
      called <= called_addr;
      ctype <= comm_type;
      reg_grp <= group_registered;
      hook <= hook_sel;
      dup <= duplex_sel;
      cause <= release_cause;
      now <= now_ms;
      vcnt <= voice_count;
    end
    if (wr_en && count < CNT_W'(MAX_RES)) rbuf[count] <= ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_cfg <= STALE_RST;
      spacing_cfg <= SPACING_RST;
      marker_cfg <= MARKER_RST;
      next_ident <= 14'd1;
      vlast <= '0;
      vbump <= '0;
      vseen <= 1'b0;
      quiet_zero <= 1'b0;
      fired2 <= 1'b0;
      count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        owner[i] <= '0;
        ident[i] <= '0;
        phase[i] <= PH_IDLE;
        gaddr[i] <= '0;
        paddr[i] <= '0;
        flags[i] <= '0;
        stg[i] <= '0;
        due[i] <= '0;
        act[i] <= '0;
        mark[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STALE: stale_cfg <= cfg_data;
          CFG_SPACING: spacing_cfg <= cfg_data[15:0];
          CFG_MARKER: marker_cfg <= cfg_data[5:0];
          default: ;
        endcase
      end

      if (cmd.capture) begin
        count <= '0;
      end else if (wr_en && count < CNT_W'(MAX_RES)) begin
        count <= count + 1'b1;
      end

      if (cmd.req && !bad) begin
        if (rq == REQ_SETUP) begin
          if (setup_ok) begin
            if (alloc) begin
              owner[sreq] <= caller;
              ident[sreq] <= next_ident;
              mark[sreq] <= marker_cfg;
              next_ident <= nid_inc;
              flags[sreq] <= {1'b0, dup, hook};
            end else begin
              flags[sreq] <= {flags[sreq][2], dup, hook};
            end
            gaddr[sreq] <= g ? cp : 24'd0;
            paddr[sreq] <= g ? 24'd0 : cp;
            stg[sreq] <= 2'd1;
            due[sreq] <= now + {16'd0, spacing_cfg};
            act[sreq] <= now;
            phase[sreq] <= PH_CONNECTED;
          end
        end else if (found) begin
          if (rq == REQ_TXDEM) begin
            flags[fidx][2] <= !flags[fidx][2];
            phase[fidx] <= PH_TALKER;
            act[fidx] <= now;
          end else if (rq == REQ_TXCEASE) begin
            phase[fidx] <= PH_CONNECTED;
            act[fidx] <= now;
          end else begin
            owner[fidx] <= '0;
            ident[fidx] <= '0;
            phase[fidx] <= PH_IDLE;
            gaddr[fidx] <= '0;
            paddr[fidx] <= '0;
            flags[fidx] <= '0;
            stg[fidx] <= '0;
            due[fidx] <= '0;
            act[fidx] <= '0;
            mark[fidx] <= '0;
          end
        end
      end

      // A new burst count, no burst yet, or a burst at this time keeps all slots active.
      if (cmd.voice) begin
        if (vcnt != vlast) begin
          vbump <= now;
          vseen <= 1'b1;
          vlast <= vcnt;
          quiet_zero <= 1'b1;
        end else begin
          quiet_zero <= !vseen || (now == vbump);
        end
      end

      if (cmd.stage) begin
        fired2 <= fire && (stg[sl] == 2'd2);
        if (fire) begin
          if (stg[sl] == 2'd1) begin
            stg[sl] <= 2'd2;
            due[sl] <= now + {16'd0, spacing_cfg};
          end else begin
            stg[sl] <= 2'd0;
          end
        end
      end

      if (cmd.expire && occ[sl]) begin
        if (expire) begin
          owner[sl] <= '0;
          ident[sl] <= '0;
          phase[sl] <= PH_IDLE;
          gaddr[sl] <= '0;
          paddr[sl] <= '0;
          flags[sl] <= '0;
          stg[sl] <= '0;
          due[sl] <= '0;
          act[sl] <= '0;
          mark[sl] <= '0;
        end else begin
          act[sl] <= act_new;
        end
      end

      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output beat register; the mask and marker reflect the table after the whole item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ores <= rbuf[cmd.rd];
      voice_mask <= vm_now;
      marker_word <= mw_now;
      last <= (cmd.rd == count - 1'b1);
    end
  end

endmodule

[design/gccs_checker.sv]
// Port-level checks of the group call slot controller and their binding.
module gccs_checker import gccs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  result_kind,
  input logic [3:0]  voice_mask,
  input logic [31:0] marker_word,
  input logic        last
);

  // An accepted item holds off the next one while it is worked on.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after acceptance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled beat dropped");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind <= K_NOTHING)
    else $error("result kind out of range");

  a_nothing_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == K_NOTHING |-> last)
    else $error("empty result is not alone");

  a_lane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> voice_mask[2:0] == 3'd0 && marker_word[23:0] == 24'd0
      && marker_word[31:30] == 2'd0)
    else $error("traffic outside the voice lane");

endmodule

bind group_call_control_slots gccs_checker u_gccs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
  .voice_mask(voice_mask), .marker_word(marker_word), .last(last)
);

[dv/tb_group_call_control_slots.sv]
// Self-checking testbench of the group call slot controller with its own slot-table predictor.
module tb_group_call_control_slots;
  import gccs_pkg::*;

  typedef struct {
    logic        act;
    logic [2:0]  rq;
    logic [23:0] caller;
    logic [1:0]  ck;
    logic [23:0] called;
    logic [1:0]  ct;
    logic        greg;
    logic        hook;
    logic        dup;
    logic [4:0]  cause;
    logic [31:0] now;
    logic [15:0] vcnt;
  } item_t;

  typedef struct {
    res_t        r;
    logic [3:0]  vm;
    logic [31:0] mw;
    logic        lst;
  } beat_t;

  localparam int LIMIT = 900000;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_OTHER = 3'd5;
  localparam logic [2:0] REQ_UNDEF = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] result_kind;
  logic [23:0] target_addr, calling_addr;
  logic [13:0] call_ident;
  logic send_seq, is_group, hook_out, duplex_out, last;
  logic [4:0] cause_out;
  logic [3:0] voice_mask;
  logic [31:0] marker_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_STALE;
  logic [31:0] cfg_data = '0;

  item_t cur = '{default: '0};
  item_t pending[$];
  beat_t expected_beats[$];
  res_t item_beats[$];
  int errors = 0;
  int cyc = 0;
  int in_gap = 0;
  int out_gap = 0;
  int long_hold = 0;
  bit no_idle = 1'b0;

  // Predictor state.
  logic [31:0] p_stale;
  logic [15:0] p_spacing;
  logic [5:0]  p_marker;
  logic [23:0] s_owner[NSLOT];
  logic [13:0] s_id[NSLOT];
  logic [1:0]  s_ph[NSLOT];
  logic [23:0] s_grp[NSLOT];
  logic [23:0] s_peer[NSLOT];
  logic [2:0]  s_fl[NSLOT];
  logic [1:0]  s_stage[NSLOT];
  logic [31:0] s_due[NSLOT];
  logic [31:0] s_act[NSLOT];
  logic [5:0]  s_mark[NSLOT];
  logic [13:0] next_id;
  logic [15:0] vc_last;
  logic [31:0] vc_bump;
  logic        vc_seen;

  // Generator state.
  logic [31:0] gen_now = 32'd0;
  logic [15:0] gen_vc = 16'd0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  group_call_control_slots dut (.*, .action(cur.act), .req_type(cur.rq),
    .caller_addr(cur.caller), .called_kind(cur.ck), .called_addr(cur.called),
    .comm_type(cur.ct), .group_registered(cur.greg), .hook_sel(cur.hook),
    .duplex_sel(cur.dup), .release_cause(cur.cause), .now_ms(cur.now),
    .voice_count(cur.vcnt));

  function automatic void drop_slot(int i);
    s_owner[i] = '0; s_id[i] = '0; s_ph[i] = PH_IDLE; s_grp[i] = '0; s_peer[i] = '0;
    s_fl[i] = '0; s_stage[i] = '0; s_due[i] = '0; s_act[i] = '0; s_mark[i] = '0;
  endfunction

  function automatic void table_reset();
    p_stale = STALE_RST; p_spacing = SPACING_RST; p_marker = MARKER_RST;
    for (int i = 0; i < NSLOT; i++) drop_slot(i);
    next_id = 14'd1; vc_last = '0; vc_bump = '0; vc_seen = 1'b0;
  endfunction

  function automatic void add_beat(logic [3:0] k, logic [23:0] tgt, logic [23:0] cl,
                                   logic [13:0] id, logic sq, logic [4:0] cs, logic g,
                                   logic hk, logic dp);
    res_t r;
    r = '{kind: k, target: tgt, calling: cl, ident: id, seq: sq, cause: cs, grp: g,
          hook: hk, dup: dp};
    if (item_beats.size() < MAX_RES) item_beats.push_back(r);
  endfunction

  function automatic logic grp_bit(int i);
    return s_grp[i] != '0;
  endfunction

  function automatic void predict_request(item_t it);
    int si;
    logic [23:0] cp;
    logic g;
    si = -1;
    if (it.caller == '0 || it.rq > REQ_DISC) begin
      add_beat(K_INVALID, it.caller, '0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      return;
    end
    for (int i = 0; i < NSLOT; i++)
      if (si < 0 && s_owner[i] == it.caller) si = i;
    if (it.rq == REQ_SETUP) begin
      if (si < 0) begin
        si = 0;
        for (int i = 0; i < NSLOT; i++) if (s_owner[i] != '0) si = -1;
        if (si == 0) begin
          drop_slot(0);
          s_owner[0] = it.caller;
          s_id[0] = next_id;
          next_id = next_id + 14'd1;
          if (next_id == '0) next_id = 14'd1;
          s_mark[0] = p_marker;
        end
      end
      if (si < 0) begin
        add_beat(K_NOSLOT, it.caller, '0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        return;
      end
      cp = (it.ck == 2'd1 || it.ck == 2'd2) ? it.called : '0;
      g = cp != '0 && it.ct != '0 && it.greg;
      s_grp[si] = g ? cp : '0;
      s_peer[si] = g ? '0 : cp;
      s_fl[si] = {s_fl[si][2], it.dup, it.hook};
      s_stage[si] = 2'd1;
      s_due[si] = it.now + 32'(p_spacing);
      s_act[si] = it.now;
      s_ph[si] = PH_CONNECTED;
      add_beat(K_CONNECT, s_owner[si], '0, s_id[si], s_fl[si][2], '0, grp_bit(si),
               it.hook, it.dup);
      return;
    end
    if (si < 0) begin
      add_beat(K_NOCALL, it.caller, '0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      return;
    end
    case (it.rq)
      REQ_TXDEM: begin
        s_fl[si][2] = ~s_fl[si][2];
        s_ph[si] = PH_TALKER;
        s_act[si] = it.now;
        add_beat(K_GRANT, s_owner[si], '0, s_id[si], s_fl[si][2], '0, grp_bit(si),
                 1'b0, 1'b0);
      end
      REQ_TXCEASE: begin
        s_ph[si] = PH_CONNECTED;
        s_act[si] = it.now;
        add_beat(K_CEASED, grp_bit(si) ? s_grp[si] : s_owner[si], '0, s_id[si], 1'b0, '0,
                 grp_bit(si), 1'b0, 1'b0);
      end
      default: begin
        s_fl[si][2] = ~s_fl[si][2];
        add_beat(K_RELEASE, s_owner[si], '0, s_id[si], s_fl[si][2], it.cause,
                 grp_bit(si), 1'b0, 1'b0);
        drop_slot(si);
      end
    endcase
  endfunction

  function automatic void predict_tick(item_t it);
    logic [31:0] quiet, d;
    if (it.vcnt != vc_last) begin
      vc_bump = it.now; vc_seen = 1'b1; vc_last = it.vcnt;
    end
    quiet = vc_seen ? it.now - vc_bump : '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (s_owner[i] != '0) begin
        d = it.now - s_due[i];
        if (s_stage[i] != '0 && !d[31]) begin
          if (s_stage[i] == 2'd1) begin
            add_beat(K_CONNECT, s_owner[i], '0, s_id[i], s_fl[i][2], '0, grp_bit(i),
                     s_fl[i][0], s_fl[i][1]);
            s_stage[i] = 2'd2;
            s_due[i] = it.now + 32'(p_spacing);
          end else if (s_stage[i] == 2'd2) begin
            add_beat(K_CONNECT, s_owner[i], '0, s_id[i], s_fl[i][2], '0, grp_bit(i),
                     s_fl[i][0], s_fl[i][1]);
            if (s_grp[i] != '0 || s_peer[i] != '0)
              add_beat(K_SETUP, grp_bit(i) ? s_grp[i] : s_peer[i], s_owner[i], s_id[i],
                       s_fl[i][2], '0, grp_bit(i), 1'b0, 1'b0);
            s_stage[i] = '0;
          end else begin
            s_stage[i] = '0;
          end
        end
        if (quiet == '0) s_act[i] = it.now;
        if (s_ph[i] != PH_IDLE && (it.now - s_act[i]) > p_stale) begin
          add_beat(K_EXPIRED, s_owner[i], '0, s_id[i], s_fl[i][2], '0, grp_bit(i),
                   1'b0, 1'b0);
          drop_slot(i);
        end
      end
    end
  endfunction

  function automatic void predict_item(item_t it);
    logic [3:0] vm;
    logic [31:0] mw;
    item_beats.delete();
    if (it.act) predict_tick(it);
    else predict_request(it);
    if (item_beats.size() == 0)
      add_beat(K_NOTHING, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
    vm = '0;
    mw = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (s_owner[i] != '0 && s_ph[i] != PH_IDLE) vm[3] = 1'b1;
      if (s_owner[i] != '0 && s_mark[i] != '0) mw[29:24] = mw[29:24] | s_mark[i];
    end
    foreach (item_beats[k])
      expected_beats.push_back('{r: item_beats[k], vm: vm, mw: mw,
                                 lst: k == item_beats.size() - 1});
  endfunction

  // Sender: offers pending items with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_item(cur);
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        cur <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cyc, what, got, want);
    errors++;
  endtask

  // One long hold-off of the receiver, counted down here.
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 0;
    end else if (cyc == 3000) begin
      long_hold <= 400;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // Receiver: random stall bursts, the long hold-off, and field checks.
  always @(posedge clk) begin
    beat_t e;
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb_group_call_control_slots: done, errors");
      $finish;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat kind", 32'(result_kind), '0);
        end else begin
          e = expected_beats.pop_front();
          if (result_kind !== e.r.kind)
            report_mismatch("result_kind", 32'(result_kind), 32'(e.r.kind));
          if (target_addr !== e.r.target)
            report_mismatch("target_addr", 32'(target_addr), 32'(e.r.target));
          if (calling_addr !== e.r.calling)
            report_mismatch("calling_addr", 32'(calling_addr), 32'(e.r.calling));
          if (call_ident !== e.r.ident)
            report_mismatch("call_ident", 32'(call_ident), 32'(e.r.ident));
          if (send_seq !== e.r.seq)
            report_mismatch("send_seq", 32'(send_seq), 32'(e.r.seq));
          if (cause_out !== e.r.cause)
            report_mismatch("cause_out", 32'(cause_out), 32'(e.r.cause));
          if (is_group !== e.r.grp)
            report_mismatch("is_group", 32'(is_group), 32'(e.r.grp));
          if (hook_out !== e.r.hook)
            report_mismatch("hook_out", 32'(hook_out), 32'(e.r.hook));
          if (duplex_out !== e.r.dup)
            report_mismatch("duplex_out", 32'(duplex_out), 32'(e.r.dup));
          if (voice_mask !== e.vm)
            report_mismatch("voice_mask", 32'(voice_mask), 32'(e.vm));
          if (marker_word !== e.mw) report_mismatch("marker_word", marker_word, e.mw);
          if (last !== e.lst) report_mismatch("last", 32'(last), 32'(e.lst));
        end
      end
      if (cyc == 3000 || long_hold > 0) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic item_t make_item(logic act, logic [2:0] rq, logic [23:0] caller);
    item_t it;
    it.act = act; it.rq = rq; it.caller = caller;
    it.ck = 2'($urandom_range(0, 3));
    it.called = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom);
    it.ct = 2'($urandom_range(0, 3));
    it.greg = 1'($urandom_range(0, 1));
    it.hook = 1'($urandom_range(0, 1));
    it.dup = 1'($urandom_range(0, 1));
    it.cause = 5'($urandom);
    it.now = gen_now;
    it.vcnt = gen_vc;
    return it;
  endfunction

  function automatic void push_tick(int step);
    gen_now = gen_now + 32'(step);
    if ($urandom_range(0, 2) == 0) gen_vc = gen_vc + 16'(1 + $urandom_range(0, 2));
    pending.push_back(make_item(1'b1, REQ_SETUP, '0));
  endfunction

  function automatic logic [23:0] pick_caller();
    case ($urandom_range(0, 3))
      0: return 24'd1;
      1: return 24'hFFFFFF;
      2: return 24'h5A5A5A;
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  // One call: setup, connect ticks, talk spurts, then a release, a disconnect, a long tick or a new setup.
  function automatic void push_call(int spacing);
    logic [23:0] who;
    int spurts;
    who = pick_caller();
    spurts = $urandom_range(0, 3);
    pending.push_back(make_item(1'b0, REQ_SETUP, who));
    for (int k = 0; k < 3; k++) push_tick($urandom_range(0, spacing + 2));
    for (int k = 0; k < spurts; k++) begin
      pending.push_back(make_item(1'b0, REQ_TXDEM, who));
      push_tick($urandom_range(0, spacing));
      pending.push_back(make_item(1'b0, REQ_TXCEASE, ($urandom_range(0, 5) == 0)
                                  ? pick_caller() : who));
    end
    if ($urandom_range(0, 4) == 0)
      pending.push_back(make_item(1'b0, REQ_SETUP, pick_caller()));
    case ($urandom_range(0, 3))
      0: pending.push_back(make_item(1'b0, REQ_RELEASE, who));
      1: pending.push_back(make_item(1'b0, REQ_DISC, who));
      2: push_tick($urandom_range(0, 80000));
      default: pending.push_back(make_item(1'b0, REQ_SETUP, who));
    endcase
  endfunction

  function automatic void push_noise();
    item_t it;
    it = make_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), pick_caller());
    if ($urandom_range(0, 5) == 0) it.caller = '0;
    it.now = 32'($urandom);
    it.vcnt = 16'($urandom);
    pending.push_back(it);
    if (it.act) begin
      gen_now = it.now;
      gen_vc = it.vcnt;
    end
  endfunction

  task automatic wait_drained();
    while (pending.size() > 0 || in_valid || expected_beats.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STALE: p_stale = val;
      CFG_SPACING: p_spacing = val[15:0];
      default: p_marker = val[5:0];
    endcase
  endtask

  task automatic run_phase(int n, int spacing);
    int start;
    start = pending.size();
    while (pending.size() - start < n) begin
      if ($urandom_range(0, 4) == 0) push_noise();
      else push_call(spacing);
    end
  endtask

  initial begin
    table_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Directed: ticks before any voice, empty ticks, invalid and missing calls, a second call refused.
    push_tick(5);
    pending.push_back(make_item(1'b0, REQ_TXDEM, 24'd7));
    pending.push_back(make_item(1'b0, REQ_SETUP, '0));
    pending.push_back(make_item(1'b0, REQ_OTHER, 24'd9));
    pending.push_back(make_item(1'b0, REQ_UNDEF, 24'hFFFFFF));
    pending.push_back(make_item(1'b0, REQ_SETUP, 24'd1));
    pending.push_back(make_item(1'b0, REQ_SETUP, 24'd2));
    pending.push_back(make_item(1'b0, REQ_SETUP, 24'd1));
    push_tick(113);
    push_tick(113);
    pending.push_back(make_item(1'b0, REQ_TXDEM, 24'd1));
    pending.push_back(make_item(1'b0, REQ_TXCEASE, 24'd1));
    pending.push_back(make_item(1'b0, REQ_DISC, 24'd1));
    pending.push_back(make_item(1'b0, REQ_RELEASE, 24'd1));
    pending.push_back(make_item(1'b0, REQ_SETUP, 24'hFFFFFF));
    push_tick(40000);
    run_phase(100, 150);
    wait_drained();
    write_reg(CFG_STALE, 32'hFFFFFFFF);
    write_reg(CFG_SPACING, 32'd0);
    write_reg(CFG_MARKER, 32'd63);
    gen_now = 32'hFFFFFF00;
    run_phase(110, 20);
    wait_drained();
    write_reg(CFG_STALE, 32'd0);
    write_reg(CFG_SPACING, 32'd65535);
    write_reg(CFG_MARKER, 32'd4);
    run_phase(70, 70000);
    wait_drained();
    write_reg(CFG_STALE, 32'd60);
    write_reg(CFG_SPACING, 32'($urandom_range(1, 200)));
    write_reg(CFG_MARKER, 32'($urandom_range(4, 63)));
    run_phase(100, 100);
    wait_drained();
    no_idle = 1'b1;
    run_phase(70, 100);
    wait_drained();
    if (errors == 0) $display("tb_group_call_control_slots: done, clean");
    else $display("tb_group_call_control_slots: done, errors");
    $finish;
  end

endmodule
